// File: rtl/core/cke_pkg.sv
`default_nettype none

package cke_pkg;

    // fixed-point format of operands and results
    localparam int VALUE_WIDTH   = 48;
    localparam int FRACTION_BITS = 16;

    // magnitude before final saturation: rounded product or rounded quotient
    localparam int MAG_WIDTH =
        (((2 * VALUE_WIDTH - FRACTION_BITS) > (VALUE_WIDTH + FRACTION_BITS)) ?
         (2 * VALUE_WIDTH - FRACTION_BITS) : (VALUE_WIDTH + FRACTION_BITS)) + 1;

    // fraction digit weight, digit * 2^fraction_bits / 10^position
    localparam int WEIGHT_WIDTH = FRACTION_BITS + 4;

    // fraction position holds 0 up to six fraction digits plus one
    localparam int POS_WIDTH = 3;

    // key kinds
    typedef enum logic [2:0] {
        KEY_DIGIT    = 3'd0,
        KEY_POINT    = 3'd1,
        KEY_OPERATOR = 3'd2,
        KEY_EQUALS   = 3'd3,
        KEY_CLEAR    = 3'd4
    } key_kind_t;

    // operator codes
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_code_t;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_DIG_MUL,
        DP_DIG_ADD,
        DP_FRAC_ADD,
        DP_ECHO,
        DP_SUM,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_MUL_ROUND,
        DP_DIV_ROUND,
        DP_PACK,
        DP_FIRST
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic                   sel_second;
        logic                   subtract;
        logic [3:0]             digit;
        logic [POS_WIDTH-1:0]   frac_pos;
    } dp_cmd_t;

    typedef struct packed {
        logic second_zero;
    } dp_status_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] digit_value;
        logic [2:0] operator_code;
    } key_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] display_value;
        logic                          is_result;
        logic                          saturated;
    } res_item_t;

endpackage

`default_nettype wire

// File: rtl/core/calculator_key_engine_core.sv
// Key-press engine of a four-function calculator: one key beat at a time (digit, decimal
// point, operator, equals, clear), operands and results in signed fixed point with 16
// fraction bits, saturated on overflow. A digit yields an echo beat of the operand being
// entered, equals yields a result beat; point, operator and clear keys yield no beat.
// Point, operator and clear are handled in the idle state; an integer digit scales the
// operand by ten and then adds the digit, a fraction digit adds its weight; add and
// subtract use a sum step; multiply runs a one-bit-per-cycle shift-add unit, divide a
// restoring divider that retires one quotient bit per cycle, each then rounds and packs.
// A new key is taken while a finished beat still waits in the result register; the last
// step of the next key waits until that register is free.
`default_nettype none

module calculator_key_engine_core #(
    parameter int MAX_FRACTION_DIGITS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_valid,
    output logic               key_ready,
    input  cke_pkg::key_item_t key_item,
    output logic               res_valid,
    input  logic               res_ready,
    output cke_pkg::res_item_t res_item
);
    import cke_pkg::*;

    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic                    is_result;
    logic [VALUE_WIDTH-1:0]  value;
    logic                    value_sat;

    // key sequencing
    cke_ctrl #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_ready     (key_ready),
        .key_item      (key_item),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_is_result (is_result),
        .cmd           (cmd),
        .status        (status)
    );

    // operands and arithmetic
    cke_datapath #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .value_sat (value_sat)
    );

    // result beat
    assign res_item.display_value = value;
    assign res_item.is_result     = is_result;
    assign res_item.saturated     = value_sat;

endmodule

`default_nettype wire

// File: rtl/core/cke_datapath.sv
`default_nettype none

module cke_datapath #(
    parameter int MAX_FRACTION_DIGITS = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cke_pkg::dp_cmd_t                      cmd,
    output cke_pkg::dp_status_t                   status,
    output logic signed [cke_pkg::VALUE_WIDTH-1:0] value,
    output logic                                  value_sat
);
    import cke_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int FB    = FRACTION_BITS;
    localparam int IDX_W = (MAX_FRACTION_DIGITS > 1) ? $clog2(MAX_FRACTION_DIGITS) : 1;

    localparam logic [W-1:0]         MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         MIN_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [MAG_WIDTH-1:0] LIM_NEG = MAG_WIDTH'(1) << (W - 1);
    localparam logic [MAG_WIDTH-1:0] LIM_POS = LIM_NEG - MAG_WIDTH'(1);

    // operand state
    logic [W-1:0] first_reg, first_next;
    logic [W-1:0] second_reg, second_next;

    // working registers
    logic [W-1:0]         work_reg, work_next;
    logic                 work_sat_reg, work_sat_next;
    logic [W-1:0]         mcand_reg, mcand_next;
    logic [W-1:0]         hi_reg, hi_next;
    logic [W+FB-1:0]      lo_reg, lo_next;
    logic [MAG_WIDTH-1:0] mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [W-1:0]         val_reg, val_next;
    logic                 val_sat_reg, val_sat_next;

    // fraction weight table, rounded half up
    logic [WEIGHT_WIDTH-1:0] frac_tab [10][MAX_FRACTION_DIGITS];

    for (genvar gd = 0; gd < 10; gd++) begin : g_digit
        for (genvar gp = 0; gp < MAX_FRACTION_DIGITS; gp++) begin : g_pos
            localparam longint unsigned POW = 10 ** (gp + 1);
            localparam longint unsigned WT  = ((64'(gd) << FB) + POW / 2) / POW;
            assign frac_tab[gd][gp] = WEIGHT_WIDTH'(WT);
        end
    end

    logic [W-1:0]            opnd;
    logic [W-1:0]            abs_first;
    logic [W-1:0]            abs_second;
    logic [IDX_W-1:0]        frac_idx;
    logic [WEIGHT_WIDTH-1:0] weight;
    logic [W+4:0]            prod10;
    logic                    prod10_ovf;
    logic [W:0]              dig_sum;
    logic [W:0]              frac_sum;
    logic [W+1:0]            a_ext;
    logic [W+1:0]            b_ext;
    logic [W+1:0]            ab_sum;
    logic                    ab_ovf;
    logic [W:0]              mul_t;
    logic [W:0]              rem_sh;
    logic [W:0]              rem_diff;
    logic                    rem_ge;
    logic [2*W-1:0]          prod;
    logic                    div_half;

    // shared operand and magnitude terms
    always_comb
    begin
        opnd       = cmd.sel_second ? second_reg : first_reg;
        abs_first  = first_reg[W-1] ? (W'(0) - first_reg) : first_reg;
        abs_second = second_reg[W-1] ? (W'(0) - second_reg) : second_reg;
        frac_idx   = IDX_W'(cmd.frac_pos - POS_WIDTH'(1));
        weight     = frac_tab[cmd.digit][frac_idx];
    end

    // digit entry arithmetic
    always_comb
    begin
        prod10     = {{5{opnd[W-1]}}, opnd} * (W+5)'(10);
        prod10_ovf = !((&prod10[W+4:W-1]) || !(|prod10[W+4:W-1]));
        dig_sum    = {work_reg[W-1], work_reg} + ((W+1)'(cmd.digit) << FB);
        frac_sum   = {opnd[W-1], opnd} + (W+1)'(weight);
    end

    // add and subtract
    always_comb
    begin
        a_ext  = {{2{first_reg[W-1]}}, first_reg};
        b_ext  = {{2{second_reg[W-1]}}, second_reg};
        ab_sum = cmd.subtract ? (a_ext - b_ext) : (a_ext + b_ext);
        ab_ovf = !((&ab_sum[W+1:W-1]) || !(|ab_sum[W+1:W-1]));
    end

    // shift-add multiply and restoring divide steps, rounding terms
    always_comb
    begin
        mul_t    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : (W+1)'(0));
        rem_sh   = {hi_reg, lo_reg[W+FB-1]};
        rem_diff = rem_sh - {1'b0, mcand_reg};
        rem_ge   = rem_sh >= {1'b0, mcand_reg};
        prod     = {hi_reg, lo_reg[W-1:0]};
        div_half = {hi_reg, 1'b0} >= {1'b0, mcand_reg};
    end

    // next values per command
    always_comb
    begin
        first_next    = first_reg;
        second_next   = second_reg;
        work_next     = work_reg;
        work_sat_next = work_sat_reg;
        mcand_next    = mcand_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        val_next      = val_reg;
        val_sat_next  = val_sat_reg;

        case (cmd.op)
            DP_CLEAR:
            begin
                first_next  = '0;
                second_next = '0;
            end
            DP_DIG_MUL:
            begin
                work_sat_next = prod10_ovf;
                if (prod10_ovf)
                begin
                    work_next = prod10[W+4] ? MIN_NEG : MAX_POS;
                end
                else
                begin
                    work_next = prod10[W-1:0];
                end
            end
            DP_DIG_ADD:
            begin
                if (dig_sum[W] != dig_sum[W-1])
                begin
                    val_next     = dig_sum[W] ? MIN_NEG : MAX_POS;
                    val_sat_next = 1'b1;
                end
                else
                begin
                    val_next     = dig_sum[W-1:0];
                    val_sat_next = work_sat_reg;
                end
                if (cmd.sel_second)
                begin
                    second_next = val_next;
                end
                else
                begin
                    first_next = val_next;
                end
            end
            DP_FRAC_ADD:
            begin
                if (frac_sum[W] != frac_sum[W-1])
                begin
                    val_next     = frac_sum[W] ? MIN_NEG : MAX_POS;
                    val_sat_next = 1'b1;
                end
                else
                begin
                    val_next     = frac_sum[W-1:0];
                    val_sat_next = 1'b0;
                end
                if (cmd.sel_second)
                begin
                    second_next = val_next;
                end
                else
                begin
                    first_next = val_next;
                end
            end
            DP_ECHO:
            begin
                val_next     = opnd;
                val_sat_next = 1'b0;
            end
            DP_SUM:
            begin
                val_sat_next = ab_ovf;
                if (ab_ovf)
                begin
                    val_next = ab_sum[W+1] ? MIN_NEG : MAX_POS;
                end
                else
                begin
                    val_next = ab_sum[W-1:0];
                end
            end
            DP_MUL_INIT:
            begin
                neg_next   = first_reg[W-1] ^ second_reg[W-1];
                mcand_next = abs_first;
                hi_next    = '0;
                lo_next    = (W+FB)'(abs_second);
            end
            DP_MUL_STEP:
            begin
                hi_next = mul_t[W:1];
                lo_next = (W+FB)'({mul_t[0], lo_reg[W-1:1]});
            end
            DP_DIV_INIT:
            begin
                neg_next   = first_reg[W-1] ^ second_reg[W-1];
                mcand_next = abs_second;
                hi_next    = '0;
                lo_next    = {abs_first, FB'(0)};
            end
            DP_DIV_STEP:
            begin
                hi_next = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
                lo_next = {lo_reg[W+FB-2:0], rem_ge};
            end
            DP_MUL_ROUND:
            begin
                mag_next = MAG_WIDTH'(prod[2*W-1:FB]) + MAG_WIDTH'(prod[FB-1]);
            end
            DP_DIV_ROUND:
            begin
                mag_next = MAG_WIDTH'(lo_reg) + MAG_WIDTH'(div_half);
            end
            DP_PACK:
            begin
                if (neg_reg)
                begin
                    val_sat_next = mag_reg > LIM_NEG;
                    val_next     = (mag_reg > LIM_NEG) ? MIN_NEG : (W'(0) - mag_reg[W-1:0]);
                end
                else
                begin
                    val_sat_next = mag_reg > LIM_POS;
                    val_next     = (mag_reg > LIM_POS) ? MAX_POS : mag_reg[W-1:0];
                end
            end
            DP_FIRST:
            begin
                val_next     = first_reg;
                val_sat_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // operand state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        work_sat_reg <= work_sat_next;
        mcand_reg    <= mcand_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        val_reg      <= val_next;
        val_sat_reg  <= val_sat_next;
    end

    assign status.second_zero = (second_reg == '0);
    assign value              = val_reg;
    assign value_sat          = val_sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/cke_ctrl.sv
`default_nettype none

module cke_ctrl #(
    parameter int MAX_FRACTION_DIGITS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_ready,
    input  cke_pkg::key_item_t  key_item,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                res_is_result,
    output cke_pkg::dp_cmd_t    cmd,
    input  cke_pkg::dp_status_t status
);
    import cke_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + FRACTION_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIG_ADD,
        S_FRAC,
        S_ECHO,
        S_SUM,
        S_MUL,
        S_DIV,
        S_ROUND,
        S_PACK,
        S_FIRST
    } state_t;

    state_t               state_reg, state_next;
    op_code_t             pend_reg, pend_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [3:0]           digit_reg, digit_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 is_result_reg, is_result_next;
    logic                 slot_free;

    assign slot_free = !res_valid_reg || res_ready;

    // sequencing and key decode
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        digit_next     = digit_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        is_result_next = is_result_reg;

        cmd.op         = DP_NOP;
        cmd.sel_second = (pend_reg != OP_NONE);
        cmd.subtract   = (pend_reg == OP_SUB);
        cmd.digit      = digit_reg;
        cmd.frac_pos   = pos_reg;

        // result beat taken
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (key_valid)
                begin
                    digit_next = key_item.digit_value;
                    case (key_item.req_type)
                        KEY_DIGIT:
                        begin
                            if (key_item.digit_value <= 4'd9)
                            begin
                                if (pos_reg == '0)
                                begin
                                    cmd.op     = DP_DIG_MUL;
                                    state_next = S_DIG_ADD;
                                end
                                else if (pos_reg <= POS_WIDTH'(MAX_FRACTION_DIGITS))
                                begin
                                    state_next = S_FRAC;
                                end
                                else
                                begin
                                    state_next = S_ECHO;
                                end
                            end
                        end
                        KEY_POINT:
                        begin
                            if (pos_reg == '0)
                            begin
                                pos_next = POS_WIDTH'(1);
                            end
                        end
                        KEY_OPERATOR:
                        begin
                            if (key_item.operator_code inside {[OP_ADD:OP_DIV]})
                            begin
                                pend_next = op_code_t'(key_item.operator_code);
                                pos_next  = '0;
                            end
                        end
                        KEY_EQUALS:
                        begin
                            pos_next = '0;
                            case (pend_reg)
                                OP_ADD, OP_SUB:
                                begin
                                    state_next = S_SUM;
                                end
                                OP_MUL:
                                begin
                                    cmd.op     = DP_MUL_INIT;
                                    cnt_next   = '0;
                                    state_next = S_MUL;
                                end
                                OP_DIV:
                                begin
                                    if (status.second_zero)
                                    begin
                                        state_next = S_FIRST;
                                    end
                                    else
                                    begin
                                        cmd.op     = DP_DIV_INIT;
                                        cnt_next   = '0;
                                        state_next = S_DIV;
                                    end
                                end
                                default:
                                begin
                                    state_next = S_FIRST;
                                end
                            endcase
                        end
                        KEY_CLEAR:
                        begin
                            pend_next = OP_NONE;
                            pos_next  = '0;
                            cmd.op    = DP_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIG_ADD, S_FRAC, S_ECHO, S_SUM, S_PACK, S_FIRST:
            begin
                // final step loads the result register once it is free
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    is_result_next = 1'b0;
                    state_next     = S_IDLE;
                    case (state_reg)
                        S_DIG_ADD:
                        begin
                            cmd.op = DP_DIG_ADD;
                        end
                        S_FRAC:
                        begin
                            cmd.op   = DP_FRAC_ADD;
                            pos_next = pos_reg + POS_WIDTH'(1);
                        end
                        S_ECHO:
                        begin
                            cmd.op = DP_ECHO;
                        end
                        S_SUM:
                        begin
                            cmd.op         = DP_SUM;
                            is_result_next = 1'b1;
                        end
                        S_PACK:
                        begin
                            cmd.op         = DP_PACK;
                            is_result_next = 1'b1;
                        end
                        default:
                        begin
                            cmd.op         = DP_FIRST;
                            is_result_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.op   = DP_MUL_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_DIV:
            begin
                cmd.op   = DP_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_WIDTH + FRACTION_BITS - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.op     = (pend_reg == OP_MUL) ? DP_MUL_ROUND : DP_DIV_ROUND;
                state_next = S_PACK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= OP_NONE;
            pos_reg       <= '0;
            digit_reg     <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            is_result_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            digit_reg     <= digit_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            is_result_reg <= is_result_next;
        end
    end

    assign key_ready     = (state_reg == S_IDLE);
    assign res_valid     = res_valid_reg;
    assign res_is_result = is_result_reg;

endmodule

`default_nettype wire

// File: tb/sv/calculator_key_engine_core_test.sv
`timescale 1ns / 100ps

module calculator_key_engine_core_test;

    import cke_pkg::*;

    localparam int VW = cke_pkg::VALUE_WIDTH;
    localparam int FB = cke_pkg::FRACTION_BITS;
    localparam int MAX_FRAC = 4;
    localparam int KEY_TARGET = 1725;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_TRIGGER = 400;
    localparam int HOLD_CYCLES = 600;

    // out-of-range codes the block must drop
    localparam logic [2:0] KEY_KIND_TOP = 3'd7;
    localparam logic [2:0] OP_CODE_TOP  = 3'd7;
    localparam logic [3:0] DIGIT_TOP    = 4'd15;

    typedef logic [127:0] wide_t;

    typedef struct packed {
        key_item_t key;
        logic      hold;
    } pending_key_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      key_valid = 1'b0;
    logic      key_ready;
    key_item_t key_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_item;

    pending_key_t key_queue[$];
    res_item_t    expected_results[$];

    // calculator state as the block should hold it
    longint      entry_first;
    longint      entry_second;
    op_code_t    entry_op;
    int unsigned entry_pos;
    bit          clamp_hit;

    // stimulus and bookkeeping
    int  keys_planned = 0;
    bit  hold_pending = 1'b0;
    int  keys_taken = 0;
    bit  key_fire = 1'b0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  equals_seen = 0;
    int  clamped_seen = 0;
    int  negative_seen = 0;
    int  cycle_count = 0;

    // sender burst state
    int        burst_left = 20;
    int        gap_left = 0;
    logic      key_next_valid;
    key_item_t key_next;

    // receiver stall state
    int   hold_left = 0;
    bit   long_hold_done = 1'b0;
    int   stall_mode = 0;
    int   stall_mode_left = 0;
    int   stall_phase = 0;
    logic ready_next;

    calculator_key_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_item  (key_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------

    function automatic wide_t mag_of(longint a);
        logic [63:0] m;
        m = (a < 0) ? -a : a;
        return wide_t'(m);
    endfunction

    // sign and magnitude to a clamped fixed-point value
    function automatic longint clamp_pack(bit neg, wide_t mag);
        wide_t top_neg;
        wide_t top_pos;
        top_neg = wide_t'(1) << (VW - 1);
        top_pos = top_neg - 1;
        if (mag == 0)
            return 0;
        if (neg)
        begin
            if (mag > top_neg)
            begin
                clamp_hit = 1'b1;
                mag = top_neg;
            end
            return -longint'(mag[63:0]);
        end
        if (mag > top_pos)
        begin
            clamp_hit = 1'b1;
            mag = top_pos;
        end
        return longint'(mag[63:0]);
    endfunction

    function automatic longint signed_sum(bit na, wide_t ma, bit nb, wide_t mb);
        if (na == nb)
            return clamp_pack(na, ma + mb);
        if (ma >= mb)
            return clamp_pack(na, ma - mb);
        return clamp_pack(nb, mb - ma);
    endfunction

    function automatic longint fixed_mul(longint a, longint b);
        wide_t prod;
        wide_t r;
        prod = mag_of(a) * mag_of(b);
        r = prod >> FB;
        if (prod[FB-1])
            r = r + 1;
        return clamp_pack((a < 0) != (b < 0), r);
    endfunction

    // divisor known nonzero
    function automatic longint fixed_div(longint a, longint b);
        wide_t num;
        wide_t d;
        wide_t q;
        wide_t rem;
        num = mag_of(a) << FB;
        d = mag_of(b);
        q = num / d;
        rem = num % d;
        if (rem >= d - rem)
            q = q + 1;
        return clamp_pack((a < 0) != (b < 0), q);
    endfunction

    function automatic longint extend_operand(longint val, int unsigned d);
        longint t;
        wide_t  p;
        wide_t  w;
        int     k;
        // integer entry: value * 10 + digit
        if (entry_pos == 0)
        begin
            t = clamp_pack(val < 0, mag_of(val) * 10);
            return signed_sum(t < 0, mag_of(t), 1'b0, wide_t'(d) << FB);
        end
        // fraction entry: rounded digit weight
        if (entry_pos <= MAX_FRAC)
        begin
            p = 1;
            for (k = 0; k < entry_pos; k++)
                p = p * 10;
            w = ((wide_t'(d) << FB) + p / 2) / p;
            entry_pos++;
            return signed_sum(val < 0, mag_of(val), 1'b0, w);
        end
        return val;
    endfunction

    task automatic apply_key(input key_item_t k);
        longint    val;
        bit        emit;
        bit        is_eq;
        res_item_t r;
        clamp_hit = 1'b0;
        emit = 1'b0;
        is_eq = 1'b0;
        val = 0;
        case (k.req_type)
            KEY_DIGIT:
            begin
                if (k.digit_value <= 9)
                begin
                    if (entry_op != OP_NONE)
                    begin
                        entry_second = extend_operand(entry_second, k.digit_value);
                        val = entry_second;
                    end
                    else
                    begin
                        entry_first = extend_operand(entry_first, k.digit_value);
                        val = entry_first;
                    end
                    emit = 1'b1;
                end
            end
            KEY_POINT:
            begin
                if (entry_pos == 0)
                    entry_pos = 1;
            end
            KEY_OPERATOR:
            begin
                if (k.operator_code >= OP_ADD && k.operator_code <= OP_DIV)
                begin
                    entry_op = op_code_t'(k.operator_code);
                    entry_pos = 0;
                end
            end
            KEY_EQUALS:
            begin
                emit = 1'b1;
                is_eq = 1'b1;
                case (entry_op)
                    OP_ADD:
                        val = signed_sum(entry_first < 0, mag_of(entry_first),
                                         entry_second < 0, mag_of(entry_second));
                    OP_SUB:
                        val = signed_sum(entry_first < 0, mag_of(entry_first),
                                         !(entry_second < 0), mag_of(entry_second));
                    OP_MUL:
                        val = fixed_mul(entry_first, entry_second);
                    OP_DIV:
                        val = (entry_second != 0) ? fixed_div(entry_first, entry_second)
                                                  : entry_first;
                    default:
                        val = entry_first;
                endcase
                entry_pos = 0;
            end
            KEY_CLEAR:
            begin
                entry_first = 0;
                entry_second = 0;
                entry_op = OP_NONE;
                entry_pos = 0;
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            r.display_value = val[VW-1:0];
            r.is_result = is_eq;
            r.saturated = clamp_hit;
            expected_results.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus planning
    // ---------------------------------------------------------------

    function automatic void queue_key(logic [2:0] kind, logic [3:0] digit, logic [2:0] op);
        pending_key_t p;
        p.key.req_type = kind;
        p.key.digit_value = digit;
        p.key.operator_code = op;
        p.hold = hold_pending;
        hold_pending = 1'b0;
        key_queue.push_back(p);
        // dropped keys do not count toward the amount of stimulus
        if (kind <= KEY_CLEAR && !(kind == KEY_DIGIT && digit > 9) &&
            !(kind == KEY_OPERATOR && (op < OP_ADD || op > OP_DIV)))
            keys_planned++;
    endfunction

    // integer digits, then maybe a point and fraction digits
    function automatic void plan_operand();
        int n_int;
        int n_frac;
        bit zeros;
        int i;
        zeros = ($urandom_range(0, 7) == 0);
        n_int = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        for (i = 0; i < n_int; i++)
            queue_key(KEY_DIGIT, zeros ? 4'd0 : 4'($urandom_range(0, 9)),
                      3'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 1)
        begin
            queue_key(KEY_POINT, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            n_frac = $urandom_range(0, 6);
            for (i = 0; i < n_frac; i++)
                queue_key(KEY_DIGIT, zeros ? 4'd0 : 4'($urandom_range(0, 9)),
                          3'($urandom_range(0, 7)));
        end
    endfunction

    function automatic void plan_random_keys();
        int i;
        int n;
        hold_pending = 1'b1;
        while (keys_planned < KEY_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
                hold_pending = 1'b1;
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed calculation with random content
                if ($urandom_range(0, 3) == 0)
                    queue_key(KEY_CLEAR, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
                plan_operand();
                queue_key(KEY_OPERATOR, 4'($urandom_range(0, 15)),
                          3'($urandom_range(OP_ADD, OP_DIV)));
                plan_operand();
                queue_key(KEY_EQUALS, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
                // keep going from the same operands
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        queue_key(KEY_OPERATOR, 4'($urandom_range(0, 15)),
                                  3'($urandom_range(OP_ADD, OP_DIV)));
                    plan_operand();
                    queue_key(KEY_EQUALS, 4'($urandom_range(0, 15)),
                              3'($urandom_range(0, 7)));
                end
            end
            else
            begin
                // noise, including dropped codes
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    queue_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                              3'($urandom_range(0, 7)));
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // key driver: bursts with random gaps, optional drain before a beat
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            key_valid <= 1'b0;
        else if (!key_valid || key_fire)
        begin
            key_next_valid = 1'b0;
            key_next = key_item;
            if (gap_left > 0)
                gap_left--;
            else if (key_queue.size() > 0 &&
                     !(key_queue[0].hold && expected_results.size() != 0))
            begin
                key_next_valid = 1'b1;
                key_next = key_queue[0].key;
                key_queue.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
            end
            key_valid <= key_next_valid;
            key_item <= key_next;
        end
    end

    // ---------------------------------------------------------------
    // result ready: changing stall patterns plus one long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (!long_hold_done && keys_taken >= HOLD_TRIGGER)
            begin
                hold_left = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall_mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(50, 300);
            end
            stall_mode_left--;
            stall_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) == 1);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ((stall_phase % 7) < 4);
                endcase
            end
            res_ready <= ready_next;
        end
    end

    // ---------------------------------------------------------------
    // monitor: check result beats, predict on accepted key beats
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input res_item_t want,
                                   input res_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) cycle %0d: want value %0d result %0b clamp %0b, got value %0d result %0b clamp %0b",
                     what, cycle_count, want.display_value, want.is_result, want.saturated,
                     got.display_value, got.is_result, got.saturated);
    endtask

    always @(posedge clk)
    begin : beat_monitor
        res_item_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (res_item.is_result)
                    equals_seen++;
                if (res_item.saturated)
                    clamped_seen++;
                if (res_item.display_value < 0)
                    negative_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", '0, res_item);
                else
                begin
                    want = expected_results.pop_front();
                    if (want.display_value !== res_item.display_value ||
                        want.is_result !== res_item.is_result ||
                        want.saturated !== res_item.saturated)
                        report_mismatch("wrong field", want, res_item);
                end
            end
            key_fire = key_valid && key_ready;
            if (key_fire)
            begin
                apply_key(key_item);
                keys_taken++;
            end
        end
    end

    // ---------------------------------------------------------------
    // timeout
    // ---------------------------------------------------------------
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        entry_first = 0;
        entry_second = 0;
        entry_op = OP_NONE;
        entry_pos = 0;

        // equals before any operator, digit entry limits, dropped keys
        queue_key(KEY_EQUALS, DIGIT_TOP, OP_CODE_TOP);
        queue_key(KEY_DIGIT, 4'd9, OP_CODE_TOP);
        queue_key(KEY_DIGIT, DIGIT_TOP, OP_ADD);
        queue_key(KEY_KIND_TOP, 4'd5, OP_MUL);
        queue_key(KEY_POINT, 4'd0, OP_NONE);
        queue_key(KEY_DIGIT, 4'd1, OP_NONE);
        queue_key(KEY_DIGIT, 4'd2, OP_NONE);
        queue_key(KEY_DIGIT, 4'd3, OP_NONE);
        queue_key(KEY_DIGIT, 4'd4, OP_NONE);
        // one fraction digit too many leaves the operand alone
        queue_key(KEY_DIGIT, 4'd5, OP_NONE);
        queue_key(KEY_POINT, DIGIT_TOP, OP_CODE_TOP);
        queue_key(KEY_OPERATOR, 4'd0, OP_NONE);
        queue_key(KEY_OPERATOR, 4'd0, OP_CODE_TOP);
        // divide by zero, then a real divide
        queue_key(KEY_OPERATOR, 4'd9, OP_DIV);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);
        queue_key(KEY_DIGIT, 4'd0, OP_NONE);
        queue_key(KEY_DIGIT, 4'd3, OP_NONE);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);
        queue_key(KEY_OPERATOR, 4'd0, OP_MUL);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);
        queue_key(KEY_OPERATOR, 4'd0, OP_SUB);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);
        queue_key(KEY_OPERATOR, 4'd0, OP_ADD);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);
        // negative result from a cleared first operand
        queue_key(KEY_CLEAR, DIGIT_TOP, OP_CODE_TOP);
        queue_key(KEY_OPERATOR, 4'd0, OP_SUB);
        queue_key(KEY_DIGIT, 4'd8, OP_NONE);
        queue_key(KEY_EQUALS, 4'd0, OP_NONE);

        plan_random_keys();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all keys to go in and all results to come back
        while (key_queue.size() != 0 || key_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0d expected beats never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        $display("covered %0d key beats and %0d result beats: %0d equals, %0d clamped, %0d negative",
                 keys_taken, results_seen, equals_seen, clamped_seen, negative_seen);
        $display("mismatch count %0d over %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: calculator_key_engine_core.f
rtl/core/cke_pkg.sv
rtl/core/cke_datapath.sv
rtl/core/cke_ctrl.sv
rtl/core/calculator_key_engine_core.sv
tb/sv/calculator_key_engine_core_test.sv
